// ===== sv/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, constants and sequence tables for the SSS sequence generator.
// ----------------------------------------------------------------------------
package sss_pkg;

  // sequence geometry
  localparam int unsigned SSS_SEQ_LEN    = 31;
  localparam int unsigned SSS_LAST_N     = 30;
  localparam int unsigned SSS_MAX_GROUP  = 167;
  localparam int unsigned SSS_MAX_SECTOR = 2;
  localparam int unsigned SSS_C1_SHIFT   = 3;

  // widths of the identity and chip fields
  localparam int unsigned SSS_GROUP_W  = 8;
  localparam int unsigned SSS_SECTOR_W = 2;
  localparam int unsigned SSS_IDX_W    = 5;

  // reciprocal constants for divide by 30 and by 31 over the group range
  localparam int unsigned SSS_RECIP_SHIFT = 13;
  localparam int unsigned SSS_DIV30_RECIP = 274;
  localparam int unsigned SSS_DIV31_RECIP = 265;

  // default depth of the queue between front and back
  localparam int unsigned SSS_QUEUE_DEPTH = 2;

  // one decoded identity handed from front to back
  typedef struct packed {
    logic                    bad;
    logic [SSS_SECTOR_W-1:0] sector;
    logic [SSS_IDX_W-1:0]    m0;
    logic [SSS_IDX_W-1:0]    m1;
  } sss_job_t;

  // length-31 m-sequence, bit i is chip i (1 means -1)
  function automatic logic [SSS_SEQ_LEN-1:0] sss_mseq(input logic [3:0] taps);
    logic [SSS_SEQ_LEN-1:0] x;
    logic                   v;
    x    = '0;
    x[4] = 1'b1;
    for (int i = 0; i < 26; i++) begin
      v = x[i] ^ (taps[0] & x[i+1]) ^ (taps[1] & x[i+2])
               ^ (taps[2] & x[i+3]) ^ (taps[3] & x[i+4]);
      x[i+5] = v;
    end
    return x;
  endfunction

  localparam logic [SSS_SEQ_LEN-1:0] SSS_S_SEQ = sss_mseq(4'b0010);
  localparam logic [SSS_SEQ_LEN-1:0] SSS_C_SEQ = sss_mseq(4'b0100);
  localparam logic [SSS_SEQ_LEN-1:0] SSS_Z_SEQ = sss_mseq(4'b1011);

endpackage

// ===== sv/sss_id_if.sv =====
// ----------------------------------------------------------------------------
// sss_id_if
// Valid/ready channel carrying one physical-layer identity pair.
// ----------------------------------------------------------------------------
interface sss_id_if;
  import sss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SSS_GROUP_W-1:0]  group_id;
  logic [SSS_SECTOR_W-1:0] sector_id;

  modport source (output valid, output group_id, output sector_id, input ready);
  modport sink   (input valid, input group_id, input sector_id, output ready);
endinterface

// ===== sv/sss_chip_if.sv =====
// ----------------------------------------------------------------------------
// sss_chip_if
// Valid/ready channel carrying one chip pair of the SSS for both subframes.
// ----------------------------------------------------------------------------
interface sss_chip_if;
  import sss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SSS_IDX_W-1:0] chip_index;
  logic                 sf0_even_neg;
  logic                 sf0_odd_neg;
  logic                 sf5_even_neg;
  logic                 sf5_odd_neg;
  logic                 bad_identity;
  logic                 last_chip;

  modport source (output valid, output chip_index, output sf0_even_neg,
                  output sf0_odd_neg, output sf5_even_neg, output sf5_odd_neg,
                  output bad_identity, output last_chip, input ready);
  modport sink   (input valid, input chip_index, input sf0_even_neg,
                  input sf0_odd_neg, input sf5_even_neg, input sf5_odd_neg,
                  input bad_identity, input last_chip, output ready);
endinterface

// ===== sv/sss_front.sv =====
// ----------------------------------------------------------------------------
// sss_front
// Accepts an identity, flags it when out of range and derives m0 and m1
// from the group over a few steps of reciprocal multiplies.
// ----------------------------------------------------------------------------
module sss_front (
  input  logic              clk,
  input  logic              rst,
  sss_id_if.sink            ident,
  output logic              wr_valid,
  input  logic              wr_ready,
  output sss_pkg::sss_job_t wr_job
);
  import sss_pkg::*;

  localparam logic [2:0] STEP_DONE = 3'd4;
  localparam int unsigned RS = SSS_RECIP_SHIFT;

  // triangular number k*(k+1)/2 for small k
  function automatic logic [4:0] tri_num(input logic [2:0] k);
    logic [4:0] r;
    unique case (k)
      3'd0:    r = 5'd0;
      3'd1:    r = 5'd1;
      3'd2:    r = 5'd3;
      3'd3:    r = 5'd6;
      3'd4:    r = 5'd10;
      3'd5:    r = 5'd15;
      3'd6:    r = 5'd21;
      default: r = 5'd28;
    endcase
    return r;
  endfunction

  logic                    busy;
  logic [2:0]              step;
  logic [SSS_GROUP_W-1:0]  group;
  logic [SSS_SECTOR_W-1:0] sector;
  logic                    bad;
  logic [2:0]              qp;
  logic [2:0]              q;
  logic [7:0]              mp;
  logic [2:0]              quo;

  logic        accept;
  logic        done;
  logic [16:0] prod_qp;
  logic [8:0]  t_sum;
  logic [17:0] prod_q;
  logic [15:0] prod_mp;
  logic [7:0]  m_red;
  logic [5:0]  m1_sum;

  assign done        = busy && (step == STEP_DONE);
  assign ident.ready = !busy || (done && wr_ready);
  assign accept      = ident.valid && ident.ready;

  // reciprocal multiplies, one per step
  assign prod_qp = {9'd0, group} * 17'(SSS_DIV30_RECIP);
  assign t_sum   = {1'b0, group} + {4'd0, tri_num(qp)};
  assign prod_q  = {9'd0, t_sum} * 18'(SSS_DIV30_RECIP);
  assign prod_mp = {8'd0, mp} * 16'(SSS_DIV31_RECIP);

  // m0 = mp mod 31, m1 = (m0 + mp / 31 + 1) mod 31
  assign m_red  = mp - ({5'd0, quo} << 5) + {5'd0, quo};
  assign m1_sum = {1'b0, m_red[4:0]} + {3'd0, quo} + 6'd1;

  always_comb begin
    wr_valid      = done;
    wr_job.bad    = bad;
    wr_job.sector = sector;
    wr_job.m0     = m_red[4:0];
    wr_job.m1     = (m1_sum >= 6'(SSS_SEQ_LEN)) ? 5'(m1_sum - 6'(SSS_SEQ_LEN))
                                                 : m1_sum[4:0];
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (done && wr_ready) begin
      busy <= 1'b0;
    end else if (busy && step != STEP_DONE) begin
      step <= step + 3'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      group  <= ident.group_id;
      sector <= ident.sector_id;
      bad    <= (ident.group_id > 8'(SSS_MAX_GROUP))
             || (ident.sector_id > 2'(SSS_MAX_SECTOR));
    end
    if (busy) begin
      unique case (step)
        3'd0:    qp  <= prod_qp[RS+2:RS];
        3'd1:    q   <= prod_q[RS+2:RS];
        3'd2:    mp  <= group + {3'd0, tri_num(q)};
        3'd3:    quo <= prod_mp[RS+2:RS];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/sss_queue.sv =====
// ----------------------------------------------------------------------------
// sss_queue
// Small first-word-fall-through queue of decoded identities between the
// front and the back.
// ----------------------------------------------------------------------------
module sss_queue #(
  parameter int unsigned DEPTH = sss_pkg::SSS_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sss_pkg::sss_job_t wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sss_pkg::sss_job_t rd_job
);
  import sss_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  sss_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

endmodule

// ===== sv/sss_back.sv =====
// ----------------------------------------------------------------------------
// sss_back
// Walks n = 0..30 for one decoded identity, reading the rotated s, c and z
// sequences through running indices, and holds each chip word in an output
// register.
// ----------------------------------------------------------------------------
module sss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_valid,
  output logic              rd_ready,
  input  sss_pkg::sss_job_t rd_job,
  sss_chip_if.source        chip
);
  import sss_pkg::*;

  localparam logic [SSS_IDX_W-1:0] IDX_LAST = SSS_IDX_W'(SSS_LAST_N);

  // advance an index around the 31-chip ring
  function automatic logic [SSS_IDX_W-1:0] ring_inc(input logic [SSS_IDX_W-1:0] x);
    return (x == IDX_LAST) ? '0 : x + SSS_IDX_W'(1);
  endfunction

  logic                 busy;
  logic [SSS_IDX_W-1:0] n;
  logic [SSS_IDX_W-1:0] s0_idx, s1_idx, c0_idx, c1_idx, z0_idx, z1_idx;

  logic                 out_valid;
  logic [SSS_IDX_W-1:0] out_index;
  logic                 out_sf0_even, out_sf0_odd, out_sf5_even, out_sf5_odd;
  logic                 out_bad, out_last;

  logic advance;
  logic pop;
  logic s0, s1, c0, c1, z0, z1;

  assign advance = !out_valid || chip.ready;

  // take a new identity when idle, or a valid one right behind the last pair of a run
  always_comb begin
    if (!advance)          pop = 1'b0;
    else if (busy)         pop = rd_valid && (n == IDX_LAST) && !rd_job.bad;
    else                   pop = rd_valid;
  end
  assign rd_ready = pop;

  // sequence taps for the current pair
  assign s0 = SSS_S_SEQ[s0_idx];
  assign s1 = SSS_S_SEQ[s1_idx];
  assign c0 = SSS_C_SEQ[c0_idx];
  assign c1 = SSS_C_SEQ[c1_idx];
  assign z0 = SSS_Z_SEQ[z0_idx];
  assign z1 = SSS_Z_SEQ[z1_idx];

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        busy      <= (n != IDX_LAST) || pop;
      end else begin
        out_valid <= pop && rd_job.bad;
        busy      <= pop && !rd_job.bad;
      end
    end
  end

  // indices and output word
  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        out_index    <= n;
        out_sf0_even <= s0 ^ c0;
        out_sf0_odd  <= s1 ^ c1 ^ z0;
        out_sf5_even <= s1 ^ c0;
        out_sf5_odd  <= s0 ^ c1 ^ z1;
        out_bad      <= 1'b0;
        out_last     <= (n == IDX_LAST);
      end else if (pop && rd_job.bad) begin
        out_index    <= '0;
        out_sf0_even <= 1'b0;
        out_sf0_odd  <= 1'b0;
        out_sf5_even <= 1'b0;
        out_sf5_odd  <= 1'b0;
        out_bad      <= 1'b1;
        out_last     <= 1'b1;
      end
      if (pop && !rd_job.bad) begin
        n      <= '0;
        s0_idx <= rd_job.m0;
        s1_idx <= rd_job.m1;
        c0_idx <= SSS_IDX_W'(rd_job.sector);
        c1_idx <= SSS_IDX_W'(rd_job.sector) + SSS_IDX_W'(SSS_C1_SHIFT);
        z0_idx <= {2'b00, rd_job.m0[2:0]};
        z1_idx <= {2'b00, rd_job.m1[2:0]};
      end else if (busy) begin
        n      <= ring_inc(n);
        s0_idx <= ring_inc(s0_idx);
        s1_idx <= ring_inc(s1_idx);
        c0_idx <= ring_inc(c0_idx);
        c1_idx <= ring_inc(c1_idx);
        z0_idx <= ring_inc(z0_idx);
        z1_idx <= ring_inc(z1_idx);
      end
    end
  end

  assign chip.valid        = out_valid;
  assign chip.chip_index   = out_index;
  assign chip.sf0_even_neg = out_sf0_even;
  assign chip.sf0_odd_neg  = out_sf0_odd;
  assign chip.sf5_even_neg = out_sf5_even;
  assign chip.sf5_odd_neg  = out_sf5_odd;
  assign chip.bad_identity = out_bad;
  assign chip.last_chip    = out_last;

endmodule

// ===== sv/lte_sss_sequence_generator_core.sv =====
// ----------------------------------------------------------------------------
// lte_sss_sequence_generator_core
// LTE secondary sync sequence generator: identity in, 31 chip-pair words out.
// ----------------------------------------------------------------------------
// Each identity accepted on ident (group 0..167, sector 0..2) yields 31 words
// on chip, n = 0..30 in order, each holding chips 2n and 2n+1 of the
// subframe 0 and subframe 5 sequences as sign bits, with last_chip set on
// n = 30. An out-of-range identity yields one word with bad_identity and
// last_chip set and all chips zero. The back generator emits one word per
// cycle while chip is ready, and takes a queued valid identity right behind
// the last word of a run. The front decodes m0/m1 over its step sequence and
// runs ahead through a queue, so ident is taken while earlier words are
// still being sent. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module lte_sss_sequence_generator_core #(
  parameter int unsigned QUEUE_DEPTH = sss_pkg::SSS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  sss_id_if.sink     ident,
  sss_chip_if.source chip
);
  import sss_pkg::*;

  logic     wr_valid, wr_ready;
  logic     rd_valid, rd_ready;
  sss_job_t wr_job, rd_job;

  // identity decode
  sss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ident    (ident),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_job   (wr_job)
  );

  // decoupling queue
  sss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_job   (wr_job),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_job   (rd_job)
  );

  // chip generation
  sss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_job   (rd_job),
    .chip     (chip)
  );

  // error word carries no chips and closes its run
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    chip.valid && chip.bad_identity |-> chip.last_chip && chip.chip_index == '0
      && !chip.sf0_even_neg && !chip.sf0_odd_neg
      && !chip.sf5_even_neg && !chip.sf5_odd_neg)
    else $error("error word carries chip data");

  // a run ends exactly at the last pair index
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    chip.valid && !chip.bad_identity
      |-> chip.last_chip == (chip.chip_index == SSS_IDX_W'(SSS_LAST_N)))
    else $error("last_chip out of step with chip_index");

  // decoded shifts of a valid identity stay in range with m0 below m1
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd_job.bad
      |-> rd_job.m0 < rd_job.m1 && rd_job.m1 <= SSS_IDX_W'(SSS_LAST_N))
    else $error("decoded m0/m1 out of range");

  // a taken word of a run is followed by its successor index
  a_next_index: assert property (@(posedge clk) disable iff (rst)
    chip.valid && chip.ready && !chip.last_chip && !chip.bad_identity
      ##1 chip.valid |-> chip.chip_index == $past(chip.chip_index) + SSS_IDX_W'(1))
    else $error("chip index skipped or repeated");

endmodule
